/* hw/rtl/bcd_timekeeper_sram_macros.svh */
// ============================================================================
// Timekeeper SRAM assertion macros
// Concurrent check helpers shared by the timekeeper RTL. They compile to
// nothing when SYNTHESIS is defined.
// ============================================================================
`ifndef BCD_TIMEKEEPER_SRAM_MACROS_SVH
`define BCD_TIMEKEEPER_SRAM_MACROS_SVH

`ifndef SYNTHESIS

// Flag a condition that must never be seen outside reset
`define BTK_ASSERT_NEVER(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
        else $error("btk: forbidden condition seen");

// Flag a cycle where the antecedent holds and the consequent does not
`define BTK_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("btk: implication violated");

`else

`define BTK_ASSERT_NEVER(lbl, ck, rn, cond)
`define BTK_ASSERT_IMPLY(lbl, ck, rn, ante, cons)

`endif

`endif

/* hw/rtl/btk_pkg.sv */
// ============================================================================
// Timekeeper SRAM package
// Shared types, codes, constants and BCD helpers of the timekeeper SRAM.
// ============================================================================
`default_nettype none

package btk_pkg;

    // Field widths
    localparam int ADDR_W     = 13;
    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int VARIANT_W  = 2;
    localparam int S_TDATA_W  = 24;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

    // Chip variants
    localparam logic [VARIANT_W-1:0] VAR_PLAIN      = 2'd0;
    localparam logic [VARIANT_W-1:0] VAR_CBIT       = 2'd1;
    localparam logic [VARIANT_W-1:0] VAR_CBIT_DMASK = 2'd2;
    localparam logic [VARIANT_W-1:0] VAR_CREG       = 2'd3;

    // Clock byte slots: the eight top bytes, then the century register
    localparam int MIR_NUM = 9;
    typedef logic [3:0] mir_idx_t;
    localparam mir_idx_t MIR_CTRL  = 4'd0;
    localparam mir_idx_t MIR_SEC   = 4'd1;
    localparam mir_idx_t MIR_MIN   = 4'd2;
    localparam mir_idx_t MIR_HOUR  = 4'd3;
    localparam mir_idx_t MIR_WDAY  = 4'd4;
    localparam mir_idx_t MIR_DATE  = 4'd5;
    localparam mir_idx_t MIR_MONTH = 4'd6;
    localparam mir_idx_t MIR_YEAR  = 4'd7;
    localparam mir_idx_t MIR_CENT  = 4'd8;

    typedef logic [MIR_NUM-1:0][BYTE_W-1:0] clk_bytes_t;

    // Counter values after reset (century slot first)
    localparam clk_bytes_t CNT_RESET = {8'h00, 8'h00, 8'h01, 8'h01, 8'h01,
                                        8'h00, 8'h00, 8'h00, 8'h00};

    // Bit positions
    localparam int CTRL_WRITE_BIT = 7;
    localparam int CTRL_READ_BIT  = 6;
    localparam int SEC_STOP_BIT   = 7;
    localparam int WDAY_CEN_EN    = 5;
    localparam int WDAY_CEN_BIT   = 4;
    localparam int DATE_BL_BIT    = 6;
    localparam int FLAGS_BL_BIT   = 4;

    // Field masks and limits
    localparam logic [7:0] SEC_MASK  = 8'h7f;
    localparam logic [7:0] HOUR_MASK = 8'h3f;
    localparam logic [7:0] WDAY_MASK = 8'h07;
    localparam logic [7:0] DATE_MASK = 8'h3f;
    localparam logic [7:0] MON_MASK  = 8'h1f;
    localparam logic [7:0] YEAR_MASK = 8'hff;
    localparam logic [7:0] SEC_MAX   = 8'h59;
    localparam logic [7:0] HOUR_MAX  = 8'h23;
    localparam logic [7:0] WDAY_MAX  = 8'h07;
    localparam logic [7:0] MON_MAX   = 8'h12;
    localparam logic [7:0] YEAR_MAX  = 8'h99;
    localparam logic [7:0] LEAP_FEB  = 8'h29;

    // Command queue and result buffer sizes
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

    // Classified command handed from front to back
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              in_range;
        logic              mir_hit;
        mir_idx_t          mir_idx;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } op_t;

    typedef struct packed {
        logic               full;
        logic [Q_CNT_W-1:0] cnt;
    } cmdq_stat_t;

    typedef struct packed {
        logic                 p1_valid;
        logic [OUT_CNT_W-1:0] out_cnt;
    } back_stat_t;

    // Counter update request from the back end
    typedef struct packed {
        logic              tick;
        logic              ctrl_wr;
        logic              wday_wr;
        logic [BYTE_W-1:0] data;
    } rtc_cmd_t;

    typedef struct packed {
        logic [7:0] value;
        logic       carry;
    } bump_t;

    // BCD increment of the masked field with wrap to lo above hi
    function automatic bump_t bcd_bump(input logic [7:0] v, input logic [7:0] mask,
                                       input logic [7:0] lo, input logic [7:0] hi);
        logic [8:0] n;
        logic [7:0] nv;
        bump_t      r;
        n = {1'b0, v & mask} + 9'd1;
        if (n[3:0] > 4'd9)
        begin
            n = {1'b0, n[7:4], 4'h0} + 9'h010;
        end
        r.carry = (n > {1'b0, hi});
        nv      = r.carry ? lo : n[7:0];
        r.value = (v & ~mask) | (nv & mask);
        return r;
    endfunction

    // Two-digit value of a byte read as BCD, nibbles taken as they are
    function automatic logic [7:0] bcd_value(input logic [7:0] b);
        logic [7:0] tens;
        tens = {4'h0, b[7:4]};
        return (tens << 3) + (tens << 1) + {4'h0, b[3:0]};
    endfunction

    // Last date of a month, BCD; unknown months get 31 days
    function automatic logic [7:0] month_days(input logic [7:0] m);
        logic [7:0] d;
        unique case (m)
            8'd2:                       d = 8'h28;
            8'd4, 8'd6, 8'd9, 8'd11:    d = 8'h30;
            default:                    d = 8'h31;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/btk_rtc.sv */
// ============================================================================
// Timekeeper BCD counters
// Holds control and time counters, advances them on a tick unless stopped or
// held, and reloads them from the clock bytes when the write bit is released.
// ============================================================================
`default_nettype none

module btk_rtc (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [btk_pkg::VARIANT_W-1:0]  variant,
    input  wire btk_pkg::rtc_cmd_t              cmd,
    input  wire btk_pkg::clk_bytes_t            mir,
    output btk_pkg::clk_bytes_t                 cnt_next,
    output logic                                copy_en
);
    import btk_pkg::*;

    clk_bytes_t cnt_reg;
    bump_t      b_sec, b_min, b_hour, b_wday, b_date, b_mon, b_year, b_cent;
    logic [7:0] mon_val, year_val, date_top;
    logic       run, c_min, c_hour, c_day, c_mon, c_year, c_cent, cbit_var;

    // Candidate increments from the current counts
    always_comb
    begin
        mon_val  = bcd_value(cnt_reg[MIR_MONTH]);
        year_val = bcd_value(cnt_reg[MIR_YEAR]);
        if (mon_val == 8'd2 && year_val[1:0] == 2'b00)
        begin
            date_top = LEAP_FEB;
        end
        else
        begin
            date_top = month_days(mon_val);
        end
        b_sec  = bcd_bump(cnt_reg[MIR_SEC], SEC_MASK, 8'h00, SEC_MAX);
        b_min  = bcd_bump(cnt_reg[MIR_MIN], SEC_MASK, 8'h00, SEC_MAX);
        b_hour = bcd_bump(cnt_reg[MIR_HOUR], HOUR_MASK, 8'h00, HOUR_MAX);
        b_wday = bcd_bump(cnt_reg[MIR_WDAY], WDAY_MASK, 8'h01, WDAY_MAX);
        b_date = bcd_bump(cnt_reg[MIR_DATE], DATE_MASK, 8'h01, date_top);
        b_mon  = bcd_bump(cnt_reg[MIR_MONTH], MON_MASK, 8'h01, MON_MAX);
        b_year = bcd_bump(cnt_reg[MIR_YEAR], YEAR_MASK, 8'h00, YEAR_MAX);
        b_cent = bcd_bump(cnt_reg[MIR_CENT], YEAR_MASK, 8'h00, YEAR_MAX);
    end

    // Ripple the carries from seconds up to century
    assign run      = !cnt_reg[MIR_SEC][SEC_STOP_BIT] && !cnt_reg[MIR_CTRL][CTRL_WRITE_BIT];
    assign c_min    = b_sec.carry;
    assign c_hour   = c_min && b_min.carry;
    assign c_day    = c_hour && b_hour.carry;
    assign c_mon    = c_day && b_date.carry;
    assign c_year   = c_mon && b_mon.carry;
    assign c_cent   = c_year && b_year.carry;
    assign cbit_var = (variant == VAR_CBIT) || (variant == VAR_CBIT_DMASK);
    assign copy_en  = cmd.tick && run && !cnt_reg[MIR_CTRL][CTRL_READ_BIT];

    // Next counter values
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.tick && run)
        begin
            cnt_next[MIR_SEC] = b_sec.value;
            if (c_min)
            begin
                cnt_next[MIR_MIN] = b_min.value;
            end
            if (c_hour)
            begin
                cnt_next[MIR_HOUR] = b_hour.value;
            end
            if (c_day)
            begin
                cnt_next[MIR_WDAY] = b_wday.value;
                cnt_next[MIR_DATE] = b_date.value;
            end
            if (c_mon)
            begin
                cnt_next[MIR_MONTH] = b_mon.value;
            end
            if (c_year)
            begin
                cnt_next[MIR_YEAR] = b_year.value;
            end
            if (c_cent)
            begin
                cnt_next[MIR_CENT] = b_cent.value;
                if (cbit_var && cnt_reg[MIR_WDAY][WDAY_CEN_EN])
                begin
                    cnt_next[MIR_WDAY][WDAY_CEN_BIT] = ~b_wday.value[WDAY_CEN_BIT];
                end
            end
        end
        if (cmd.ctrl_wr)
        begin
            // Releasing the write bit loads the counters from the clock bytes
            if (cnt_reg[MIR_CTRL][CTRL_WRITE_BIT] && !cmd.data[CTRL_WRITE_BIT])
            begin
                cnt_next = mir;
                if (variant != VAR_CREG)
                begin
                    cnt_next[MIR_CENT] = 8'h00;
                end
            end
            cnt_next[MIR_CTRL] = cmd.data;
        end
        if (cmd.wday_wr && cbit_var)
        begin
            cnt_next[MIR_WDAY][WDAY_CEN_EN] = cmd.data[WDAY_CEN_EN];
        end
    end

    // Counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= CNT_RESET;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/btk_front.sv */
// ============================================================================
// Timekeeper front end
// Takes input transfers, decodes address ranges and clock byte slots,
// applies the variant write masks and hands commands to the queue.
// ============================================================================
`default_nettype none

module btk_front #(
    parameter int MEM_BYTES = 8192
) (
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [btk_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic [btk_pkg::KIND_W-1:0]     s_axis_tuser,
    input  wire logic [btk_pkg::VARIANT_W-1:0]  variant,
    input  wire logic                           q_full,
    output logic                                push,
    output btk_pkg::op_t                        push_op
);
    import btk_pkg::*;

    localparam logic [31:0] MEM_END   = 32'(MEM_BYTES);
    localparam logic [31:0] CLK_BASE  = 32'(MEM_BYTES - 8);
    localparam logic [31:0] OFS_CENT  = 32'(MEM_BYTES - 15);
    localparam logic [31:0] OFS_FLAGS = 32'(MEM_BYTES - 16);

    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] wdata;
    logic [31:0]       a32;
    logic              in_range, top_hit, cent_hit, flags_hit, keep;
    mir_idx_t          idx;

    // Unpack the transfer
    assign kind  = s_axis_tuser;
    assign addr  = s_axis_tdata[ADDR_W-1:0];
    assign wdata = s_axis_tdata[ADDR_W+BYTE_W-1:ADDR_W];
    assign a32   = 32'(addr);

    // Decode the address map
    assign in_range  = a32 < MEM_END;
    assign top_hit   = in_range && (a32 >= CLK_BASE);
    assign cent_hit  = a32 == OFS_CENT;
    assign flags_hit = a32 == OFS_FLAGS;
    assign idx       = top_hit ? mir_idx_t'(a32 - CLK_BASE) : MIR_CENT;

    // Drop unknown kinds and writes beyond memory
    always_comb
    begin
        case (kind)
            KIND_TICK:  keep = 1'b1;
            KIND_READ:  keep = 1'b1;
            KIND_WRITE: keep = in_range;
            default:    keep = 1'b0;
        endcase
    end

    // Build the command, masking battery-low bits per variant
    always_comb
    begin
        push_op          = '0;
        push_op.kind     = kind;
        push_op.in_range = in_range;
        push_op.mir_hit  = top_hit || cent_hit;
        push_op.mir_idx  = idx;
        push_op.addr     = addr;
        push_op.data     = wdata;
        if (top_hit && idx == MIR_DATE && variant == VAR_CBIT_DMASK)
        begin
            push_op.data[DATE_BL_BIT] = 1'b0;
        end
        if (flags_hit && variant == VAR_CREG)
        begin
            push_op.data[FLAGS_BL_BIT] = 1'b0;
        end
    end

    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && s_axis_tready && keep;

endmodule

`default_nettype wire

/* hw/rtl/btk_cmdq.sv */
// ============================================================================
// Timekeeper command queue
// Two-entry queue of classified commands between front and back end.
// ============================================================================
`default_nettype none

module btk_cmdq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire btk_pkg::op_t       push_op,
    input  wire logic               pop,
    output logic                    q_valid,
    output btk_pkg::op_t            q_op,
    output btk_pkg::cmdq_stat_t     stat
);
    import btk_pkg::*;

    op_t                q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    assign q_valid   = cnt_reg != '0;
    assign q_op      = q_mem[rd_ptr_reg];
    assign stat.full = cnt_reg == Q_CNT_W'(Q_DEPTH);
    assign stat.cnt  = cnt_reg;

    // Track fill level
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/btk_back.sv */
// ============================================================================
// Timekeeper back end
// Executes one command a cycle, a read only with result buffer room:
// memory access, clock byte registers, counter updates, output result buffer.
// ============================================================================
`default_nettype none

module btk_back #(
    parameter int MEM_BYTES = 8192
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [btk_pkg::VARIANT_W-1:0]  variant,
    input  wire logic                           q_valid,
    input  wire btk_pkg::op_t                   q_op,
    output logic                                q_pop,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [btk_pkg::BYTE_W-1:0]          m_axis_tdata,  // [7:0] read_data
    output btk_pkg::back_stat_t                 stat
);
    import btk_pkg::*;

    localparam int MEM_AW = $clog2(MEM_BYTES);

    logic [BYTE_W-1:0]    ram_mem [MEM_BYTES];
    logic [BYTE_W-1:0]    ram_q_reg;
    logic [MEM_AW-1:0]    ram_addr;
    clk_bytes_t           mir_reg;
    clk_bytes_t           cnt_next;
    rtc_cmd_t             rtc_cmd;
    logic                 copy_en;
    logic                 is_tick, is_read, is_write, rd_space, rd_issue;
    logic                 host_mir_wr, ram_wr, ram_rd;
    logic                 p1_valid_reg, p1_ram_reg;
    logic [BYTE_W-1:0]    p1_byte_reg, p1_data;
    logic [BYTE_W-1:0]    out_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] out_wr_ptr_reg, out_rd_ptr_reg;
    logic [OUT_CNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic                 out_pop;

    // Decode the head command
    always_comb
    begin
        is_tick  = 1'b0;
        is_read  = 1'b0;
        is_write = 1'b0;
        case (q_op.kind)
            KIND_TICK:  is_tick  = 1'b1;
            KIND_READ:  is_read  = 1'b1;
            KIND_WRITE: is_write = 1'b1;
            default:    is_write = 1'b0;
        endcase
    end

    // Issue a read only when the result buffer has a slot reserved for it
    assign rd_space = (32'(out_cnt_reg) + 32'(p1_valid_reg)) < 32'(OUT_DEPTH);
    assign q_pop    = q_valid && (!is_read || rd_space);
    assign rd_issue = q_pop && is_read;

    assign ram_addr    = MEM_AW'(q_op.addr);
    assign host_mir_wr = q_pop && is_write && q_op.mir_hit;
    assign ram_wr      = q_pop && is_write && q_op.in_range && !q_op.mir_hit;
    assign ram_rd      = rd_issue && q_op.in_range && !q_op.mir_hit;

    // Counter requests
    always_comb
    begin
        rtc_cmd         = '0;
        rtc_cmd.tick    = q_pop && is_tick;
        rtc_cmd.ctrl_wr = host_mir_wr && (q_op.mir_idx == MIR_CTRL);
        rtc_cmd.wday_wr = host_mir_wr && (q_op.mir_idx == MIR_WDAY);
        rtc_cmd.data    = q_op.data;
    end

    btk_rtc u_rtc (
        .clk      (clk),
        .rst_n    (rst_n),
        .variant  (variant),
        .cmd      (rtc_cmd),
        .mir      (mir_reg),
        .cnt_next (cnt_next),
        .copy_en  (copy_en)
    );

    // Clock byte registers: tick copy-out or host write
    always_ff @(posedge clk)
    begin
        if (copy_en)
        begin
            mir_reg[MIR_YEAR:MIR_CTRL] <= cnt_next[MIR_YEAR:MIR_CTRL];
            if (variant == VAR_CREG)
            begin
                mir_reg[MIR_CENT] <= cnt_next[MIR_CENT];
            end
        end
        else if (host_mir_wr)
        begin
            mir_reg[q_op.mir_idx] <= q_op.data;
        end
    end

    // Byte memory, single port
    always_ff @(posedge clk)
    begin
        if (ram_wr)
        begin
            ram_mem[ram_addr] <= q_op.data;
        end
        else if (ram_rd)
        begin
            ram_q_reg <= ram_mem[ram_addr];
        end
    end

    // Read stage: remember where the result comes from
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= rd_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_issue)
        begin
            p1_ram_reg  <= q_op.in_range && !q_op.mir_hit;
            p1_byte_reg <= (q_op.in_range && q_op.mir_hit) ? mir_reg[q_op.mir_idx] : 8'h00;
        end
    end

    assign p1_data = p1_ram_reg ? ram_q_reg : p1_byte_reg;

    // Result buffer toward the output stream
    assign out_pop       = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = out_cnt_reg != '0;
    assign m_axis_tdata  = out_mem[out_rd_ptr_reg];

    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (p1_valid_reg && !out_pop)
        begin
            out_cnt_next = out_cnt_reg + 1'b1;
        end
        else if (out_pop && !p1_valid_reg)
        begin
            out_cnt_next = out_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_cnt_reg    <= '0;
        end
        else
        begin
            if (p1_valid_reg)
            begin
                out_wr_ptr_reg <= out_wr_ptr_reg + 1'b1;
            end
            if (out_pop)
            begin
                out_rd_ptr_reg <= out_rd_ptr_reg + 1'b1;
            end
            out_cnt_reg <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_valid_reg)
        begin
            out_mem[out_wr_ptr_reg] <= p1_data;
        end
    end

    assign stat.p1_valid = p1_valid_reg;
    assign stat.out_cnt  = out_cnt_reg;

endmodule

`default_nettype wire

/* hw/rtl/bcd_timekeeper_sram.sv */
// ============================================================================
// BCD timekeeper SRAM
// Byte-wide SRAM with a BCD real-time clock mapped over its top bytes.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake             | contents
//  s_axis    | in  | tvalid/tready         | tick, read or write command
//  m_axis    | out | tvalid/tready         | byte returned by a read
//  cfg       | in  | cfg_wen (no wait)     | chip variant
//
//  One command per cycle sustained while reads find room in the result
//  buffer; the single memory port takes one access per cycle and the clock
//  bytes live in registers, so a tick is executed along with its copy-out.
//  A read result passes the command queue, the read stage registers and
//  the result buffer before it raises m_axis_tvalid. Reset loads the
//  counter reset values and clears the queue and result buffer; the memory
//  is not cleared. A stalled m_axis fills a four-entry result buffer, then
//  reads wait in the two-entry command queue.
// ============================================================================
`default_nettype none
`include "bcd_timekeeper_sram_macros.svh"

module bcd_timekeeper_sram #(
    parameter int MEM_BYTES = 8192
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic [1:0]  cfg_wdata,      // [1:0] variant
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [12:0] address, [20:13] write_data
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata    // [7:0] read_data
);
    import btk_pkg::*;

    logic [VARIANT_W-1:0] variant_reg;
    logic                 push, q_valid, q_pop;
    op_t                  push_op, q_op;
    cmdq_stat_t           q_stat;
    back_stat_t           back_stat;
    logic [OUT_CNT_W:0]   out_credit;

    // Variant register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg <= VAR_PLAIN;
        end
        else if (cfg_wen)
        begin
            variant_reg <= cfg_wdata;
        end
    end

    btk_front #(
        .MEM_BYTES (MEM_BYTES)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .variant       (variant_reg),
        .q_full        (q_stat.full),
        .push          (push),
        .push_op       (push_op)
    );

    btk_cmdq u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (q_pop),
        .q_valid (q_valid),
        .q_op    (q_op),
        .stat    (q_stat)
    );

    btk_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .variant       (variant_reg),
        .q_valid       (q_valid),
        .q_op          (q_op),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .stat          (back_stat)
    );

    // Result buffer slots in use or reserved by a read in flight
    assign out_credit = {1'b0, back_stat.out_cnt} + {{OUT_CNT_W{1'b0}}, back_stat.p1_valid};

    // Checks
    `BTK_ASSERT_NEVER(a_out_credit, clk, rst_n, out_credit > (OUT_CNT_W+1)'(OUT_DEPTH))
    `BTK_ASSERT_NEVER(a_cmdq_bound, clk, rst_n, 32'(q_stat.cnt) > 32'(Q_DEPTH))
    `BTK_ASSERT_IMPLY(a_pop_nonempty, clk, rst_n, q_pop, q_valid)

endmodule

`default_nettype wire

/* sim/tb_bcd_timekeeper_sram.sv */
// ============================================================================
// Timekeeper SRAM testbench
// Drives ticks, reads and writes into the timekeeper SRAM under bursty input
// and a stalling result side, predicts every read byte with a shadow copy of
// the memory and the BCD counters, and checks each read result in order.
// ============================================================================
`default_nettype none

module tb_bcd_timekeeper_sram;

    import btk_pkg::*;

    localparam int MEM_BYTES      = 8192;
    localparam int CTRL_ADDR      = MEM_BYTES - 8;
    localparam int WDAY_ADDR      = MEM_BYTES - 4;
    localparam int DATE_ADDR      = MEM_BYTES - 3;
    localparam int MONTH_ADDR     = MEM_BYTES - 2;
    localparam int YEAR_ADDR      = MEM_BYTES - 1;
    localparam int SEC_ADDR       = MEM_BYTES - 7;
    localparam int MIN_ADDR       = MEM_BYTES - 6;
    localparam int HOUR_ADDR      = MEM_BYTES - 5;
    localparam int CENT_ADDR      = MEM_BYTES - 15;
    localparam int FLAGS_ADDR     = MEM_BYTES - 16;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 155;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // ------------------------------------------------------------------------
    // Shadow of the timekeeper: memory, counters and expected read bytes
    // ------------------------------------------------------------------------
    class timekeeper_shadow;
        logic [7:0]  mem [MEM_BYTES];
        bit          known [MEM_BYTES];
        int unsigned known_addrs[$];
        logic [7:0]  cnt [MIR_NUM];
        logic [1:0]  chip_variant;
        logic [7:0]  pending_bytes[$];
        int          errors;

        function new();
            foreach (cnt[i])
                cnt[i] = 8'h00;
            cnt[MIR_WDAY]  = 8'h01;
            cnt[MIR_DATE]  = 8'h01;
            cnt[MIR_MONTH] = 8'h01;
            chip_variant   = VAR_PLAIN;
            errors         = 0;
        endfunction

        function void set_variant(logic [1:0] v);
            chip_variant = v;
        endfunction

        // Store a byte and mark the location as safe to read
        function void remember(int unsigned a, logic [7:0] d);
            mem[a] = d;
            if (!known[a])
            begin
                known[a] = 1'b1;
                known_addrs.push_back(a);
            end
        endfunction

        // Increment one counter in BCD within its mask; return the carry
        function bit bcd_inc(mir_idx_t f, logic [7:0] mask, logic [7:0] lo, logic [7:0] hi);
            int unsigned n;
            bit          wrap;
            n = (cnt[f] & mask) + 1;
            if ((n & 'hf) > 9)
                n = (n & 'hf0) + 'h10;
            wrap = (n > hi);
            if (wrap)
                n = lo;
            cnt[f] = (cnt[f] & ~mask) | (8'(n) & mask);
            return wrap;
        endfunction

        function int unsigned bcd_to_int(logic [7:0] b);
            return b[7:4] * 10 + b[3:0];
        endfunction

        // Last date of the current month, leap February included
        function logic [7:0] last_date();
            int unsigned m;
            int unsigned y;
            m = bcd_to_int(cnt[MIR_MONTH]);
            y = bcd_to_int(cnt[MIR_YEAR]);
            if (m == 2 && (y % 4) == 0)
                return 8'h29;
            case (m)
                2:            return 8'h28;
                4, 6, 9, 11:  return 8'h30;
                default:      return 8'h31;
            endcase
        endfunction

        function void mirror_counters();
            for (int i = 0; i < 8; i++)
                remember(CTRL_ADDR + i, cnt[i]);
            if (chip_variant == VAR_CREG)
                remember(CENT_ADDR, cnt[MIR_CENT]);
        endfunction

        function void reload_counters();
            for (int i = 0; i < 8; i++)
                cnt[i] = mem[CTRL_ADDR + i];
            cnt[MIR_CENT] = (chip_variant == VAR_CREG) ? mem[CENT_ADDR] : 8'h00;
        endfunction

        // One second: ripple the carry from seconds up to century
        function void advance_second();
            bit         c;
            logic [7:0] top;
            if (cnt[MIR_SEC][SEC_STOP_BIT] || cnt[MIR_CTRL][CTRL_WRITE_BIT])
                return;
            c = bcd_inc(MIR_SEC, 8'h7f, 8'h00, 8'h59);
            if (c)
                c = bcd_inc(MIR_MIN, 8'h7f, 8'h00, 8'h59);
            if (c)
                c = bcd_inc(MIR_HOUR, 8'h3f, 8'h00, 8'h23);
            if (c)
            begin
                top = last_date();
                void'(bcd_inc(MIR_WDAY, 8'h07, 8'h01, 8'h07));
                c = bcd_inc(MIR_DATE, 8'h3f, 8'h01, top);
            end
            if (c)
                c = bcd_inc(MIR_MONTH, 8'h1f, 8'h01, 8'h12);
            if (c)
                c = bcd_inc(MIR_YEAR, 8'hff, 8'h00, 8'h99);
            if (c)
            begin
                void'(bcd_inc(MIR_CENT, 8'hff, 8'h00, 8'h99));
                if ((chip_variant == VAR_CBIT || chip_variant == VAR_CBIT_DMASK)
                    && cnt[MIR_WDAY][WDAY_CEN_EN])
                    cnt[MIR_WDAY][WDAY_CEN_BIT] = ~cnt[MIR_WDAY][WDAY_CEN_BIT];
            end
            if (!cnt[MIR_CTRL][CTRL_READ_BIT])
                mirror_counters();
        endfunction

        function void store_byte(int unsigned a, logic [7:0] d);
            logic [7:0] v;
            v = d;
            if (a == CTRL_ADDR)
            begin
                if (cnt[MIR_CTRL][CTRL_WRITE_BIT] && !v[CTRL_WRITE_BIT])
                    reload_counters();
                cnt[MIR_CTRL] = v;
            end
            else if (a == WDAY_ADDR)
            begin
                if (chip_variant == VAR_CBIT || chip_variant == VAR_CBIT_DMASK)
                    cnt[MIR_WDAY][WDAY_CEN_EN] = v[WDAY_CEN_EN];
            end
            else if (a == DATE_ADDR && chip_variant == VAR_CBIT_DMASK)
                v[DATE_BL_BIT] = 1'b0;
            else if (a == FLAGS_ADDR && chip_variant == VAR_CREG)
                v[FLAGS_BL_BIT] = 1'b0;
            remember(a, v);
        endfunction

        // Apply one accepted command to the shadow
        function void note_input(logic [1:0] kind, logic [12:0] a, logic [7:0] d);
            if (kind == KIND_TICK)
                advance_second();
            else if (kind == KIND_READ)
                pending_bytes.push_back(mem[a]);
            else if (kind == KIND_WRITE)
                store_byte(a, d);
        endfunction

        function void check_read(logic [7:0] actual);
            logic [7:0] exp_byte;
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: read byte %02h with no read pending", $time, actual);
                errors++;
                return;
            end
            exp_byte = pending_bytes.pop_front();
            if (actual !== exp_byte)
            begin
                $display("%0t: read_data mismatch: expected %02h actual %02h",
                         $time, exp_byte, actual);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_wen       = 1'b0;
    logic [1:0]  cfg_wdata     = 2'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = 24'd0;   // [12:0] address, [20:13] write_data
    logic [1:0]  s_axis_tuser  = 2'd0;    // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;            // [7:0] read_data

    timekeeper_shadow shadow = new();

    int burst_left   = 0;
    int items_sent   = 0;
    int quiet_cycles = 0;
    int rx_cycle     = 0;
    int rx_mode      = 0;

    bcd_timekeeper_sram #(
        .MEM_BYTES(MEM_BYTES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wen(cfg_wen),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Stall the result side with a randomly chosen ready pattern
    always @(posedge clk)
    begin
        if (rx_cycle % 128 == 0)
            rx_mode = $urandom_range(0, 3);
        rx_cycle++;
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ((rx_cycle % 16) < 5);
        endcase
    end

    // Check every read byte transfer
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            shadow.check_read(m_axis_tdata);
    end

    // Abort when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Send one command; bursts of random length with random gaps between
    task automatic send(input logic [1:0] kind, input logic [12:0] addr,
                        input logic [7:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 16);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {3'b000, data, addr};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        shadow.note_input(kind, addr, data);
        burst_left--;
        if (kind != KIND_UNUSED)
            items_sent++;
    endtask

    task automatic write_byte(input int a, input logic [7:0] d);
        send(KIND_WRITE, 13'(a), d);
    endtask

    task automatic read_byte(input int a);
        send(KIND_READ, 13'(a), 8'($urandom));
    endtask

    task automatic second_tick();
        send(KIND_TICK, 13'($urandom), 8'($urandom));
    endtask

    // Hold the input side idle until every read has returned
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (shadow.pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_variant(input logic [1:0] v);
        wait_idle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen <= 1'b0;
        shadow.set_variant(v);
    endtask

    // Read address: half the time a known clock area byte, else any known byte
    function automatic int pick_read_addr();
        int a;
        a = FLAGS_ADDR + $urandom_range(0, 15);
        if ($urandom_range(0, 1) == 0 || !shadow.known[a])
            a = shadow.known_addrs[$urandom_range(0, shadow.known_addrs.size() - 1)];
        return a;
    endfunction

    // Clock byte value close to a rollover, with some raw bytes mixed in
    function automatic logic [7:0] near_limit(input mir_idx_t f);
        int m;
        case (f)
            MIR_SEC:
            begin
                m = $urandom_range(0, 9);
                if (m < 6)
                    return 8'h59;
                else if (m < 8)
                    return 8'($urandom_range(0, 127));
                else if (m == 8)
                    return 8'h80 | 8'($urandom);
                return 8'h58;
            end
            MIR_MIN:   return ($urandom_range(0, 3) != 0) ? 8'h59 : 8'($urandom);
            MIR_HOUR:  return ($urandom_range(0, 3) != 0) ? 8'h23 : 8'($urandom);
            MIR_DATE:
                return ($urandom_range(0, 3) != 0) ? 8'h28 + 8'($urandom_range(0, 1))
                       + 8'h08 * 8'($urandom_range(0, 1)) * 8'($urandom_range(0, 1))
                       : 8'($urandom);
            MIR_MONTH:
            begin
                m = $urandom_range(1, 12);
                case ($urandom_range(0, 4))
                    0:       return 8'h02;
                    1:       return 8'h12;
                    2:       return 8'($urandom);
                    default: return (m < 10) ? 8'(m) : 8'(m + 6);
                endcase
            end
            MIR_YEAR:
            begin
                case ($urandom_range(0, 5))
                    0, 1:    return 8'h99;
                    2:       return 8'h04;
                    3:       return 8'h96;
                    4:       return 8'h03;
                    default: return 8'($urandom);
                endcase
            end
            MIR_CENT:  return ($urandom_range(0, 1) != 0) ? 8'h99 : 8'($urandom);
            default:   return 8'($urandom);
        endcase
    endfunction

    // Set the clock: hold with the write bit, load bytes, release, run
    task automatic set_time_and_run();
        logic [7:0] hold;
        logic [7:0] release_val;
        hold = ($urandom_range(0, 3) == 0) ? (8'h80 | 8'($urandom)) : 8'h80;
        write_byte(CTRL_ADDR, hold);
        repeat ($urandom_range(0, 2))
            second_tick();
        for (int i = 1; i < 8; i++)
        begin
            if ($urandom_range(0, 7) != 0)
                write_byte(CTRL_ADDR + i, near_limit(mir_idx_t'(i)));
        end
        if ($urandom_range(0, 3) != 0)
            write_byte(CENT_ADDR, near_limit(MIR_CENT));
        if ($urandom_range(0, 3) == 0)
            read_byte(pick_read_addr());
        release_val = ($urandom_range(0, 6) != 0) ? 8'h00 : (8'($urandom) & 8'h7f);
        write_byte(CTRL_ADDR, release_val);
        repeat ($urandom_range(1, 6))
        begin
            second_tick();
            if ($urandom_range(0, 1) == 0)
                read_byte(CTRL_ADDR + $urandom_range(0, 7));
        end
        read_byte(($urandom_range(0, 3) == 0) ? CENT_ADDR : CTRL_ADDR + $urandom_range(1, 7));
    endtask

    task automatic run_random(input int count);
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < count)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 9)
                set_time_and_run();
            else if (pick < 14)
            begin
                // scattered memory traffic over the whole address range
                repeat ($urandom_range(1, 8))
                begin
                    if ($urandom_range(0, 1) == 0)
                        write_byte($urandom_range(0, MEM_BYTES - 1), 8'($urandom));
                    else
                        read_byte(pick_read_addr());
                end
            end
            else if (pick < 18)
            begin
                repeat ($urandom_range(1, 12))
                begin
                    second_tick();
                    if ($urandom_range(0, 2) == 0)
                        read_byte(pick_read_addr());
                end
            end
            else
            begin
                // noise: unused kind and stray clock-area writes
                case ($urandom_range(0, 2))
                    0:       send(KIND_UNUSED, 13'($urandom), 8'($urandom));
                    1:       write_byte(FLAGS_ADDR + $urandom_range(0, 15), 8'($urandom));
                    default: write_byte(CTRL_ADDR, 8'($urandom));
                endcase
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_variant(VAR_PLAIN);
        // first tick mirrors the counters into the top bytes
        second_tick();
        read_byte(SEC_ADDR);
        write_byte(CENT_ADDR, 8'h98);
        write_byte(0, 8'h00);
        read_byte(0);
        write_byte(MEM_BYTES - 1, 8'hff);
        read_byte(MEM_BYTES - 1);
        send(KIND_UNUSED, 13'h1fff, 8'hff);
        // load 23:59:59 on Dec 31 of year 99 and roll everything over
        write_byte(CTRL_ADDR, 8'h80);
        write_byte(SEC_ADDR, 8'h59);
        write_byte(MIN_ADDR, 8'h59);
        write_byte(HOUR_ADDR, 8'h23);
        write_byte(WDAY_ADDR, 8'h37);
        write_byte(DATE_ADDR, 8'h31);
        write_byte(MONTH_ADDR, 8'h12);
        write_byte(YEAR_ADDR, 8'h99);
        write_byte(CTRL_ADDR, 8'h00);
        second_tick();
        read_byte(YEAR_ADDR);
        read_byte(WDAY_ADDR);
        read_byte(MONTH_ADDR);
        run_random(PHASE_ITEMS);

        set_variant(VAR_CREG);
        write_byte(FLAGS_ADDR, 8'hff);
        read_byte(FLAGS_ADDR);
        run_random(PHASE_ITEMS);

        set_variant(VAR_CBIT);
        run_random(PHASE_ITEMS);

        set_variant(VAR_CBIT_DMASK);
        write_byte(DATE_ADDR, 8'hff);
        read_byte(DATE_ADDR);
        run_random(PHASE_ITEMS);

        set_variant(VAR_CREG);
        run_random(PHASE_ITEMS);

        set_variant(VAR_PLAIN);
        run_random(PHASE_ITEMS);

        wait_idle();
        if (shadow.errors == 0 && shadow.pending_bytes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
